// ===== hw/rtl/huffman_stream_decoder_assert.svh =====
// Assertion macros for the Huffman stream decoder.
// Used by controller and top level; no other dependencies.
`ifndef HUFFMAN_STREAM_DECODER_ASSERT_SVH
`define HUFFMAN_STREAM_DECODER_ASSERT_SVH
`define HSD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define HSD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/hsd_pkg.sv =====
// Package for the Huffman stream decoder: constants, types, command structs.
// No dependencies.
package hsd_pkg;
  localparam int MaxNodes   = 512;
  localparam int StackDepth = 256;
  localparam int NodeW  = $clog2(MaxNodes);
  localparam int NfW    = $clog2(MaxNodes + 1);
  localparam int SlotW  = NodeW + 1;
  localparam int StkAW  = $clog2(StackDepth);
  localparam int SpW    = $clog2(StackDepth + 1);
  localparam int LsW    = 9;  // leaf flag + symbol
  localparam logic [7:0] EscByte  = 8'h5C;
  localparam logic [7:0] NodeByte = 8'h2A;

  typedef enum logic [1:0] {PH_HEAD0, PH_HEAD1, PH_TREE, PH_DATA} phase_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_HEAD, ST_TREE_NODE, ST_TREE_LINK, ST_TREE_PUSH,
    ST_DATA_RD, ST_DATA_EV, ST_DATA_END
  } state_t;

  typedef struct packed {
    logic load_byte;      // capture input byte
    logic head;           // header byte 0 or 1
    logic tree_node;      // decode tree byte, write node, pop slot
    logic tree_link;      // patch parent, push right slot
    logic tree_push;      // push left slot
    logic walk_read;      // issue node read for current bit
    logic walk_eval;      // evaluate read result
    logic data_end;       // flush held symbol as last of byte
    logic file_clear;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic last;
    logic take;           // tree byte creates a node
    logic have_nodes;
    logic hit;            // node read is a leaf
    logic pend_v;         // symbol held for run_last lookahead
    logic bits_last;      // current bit is the last valid one
    logic out_free;
  } sts_t;
endpackage

// ===== hw/rtl/hsd_if.sv =====
// Valid/ready stream interfaces for the Huffman stream decoder.
// Depends on nothing.
interface hsd_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface hsd_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] symbol;
  logic run_last;
  logic file_done;
  modport source (output valid, symbol, run_last, file_done, input ready);
  modport sink (input valid, symbol, run_last, file_done, output ready);
endinterface

// ===== hw/rtl/hsd_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module hsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/hsd_datapath.sv =====
// Datapath: header registers, node table, build stack, walk, output register.
// Depends on hsd_pkg and hsd_ram.
module hsd_datapath (
  input  logic clk,
  input  logic rst_n,
  input  hsd_pkg::cmd_t cmd,
  input  logic [7:0] in_byte,
  input  logic last_byte,
  input  logic out_ready,
  output hsd_pkg::sts_t sts,
  output logic out_valid,
  output logic [7:0] out_symbol,
  output logic out_run_last,
  output logic out_file_done
);
  localparam int NW = hsd_pkg::NodeW;

  hsd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] trash_r, trash_nxt;
  logic [12:0] tleft_r, tleft_nxt;
  logic esc_r, esc_nxt;
  logic [hsd_pkg::NfW-1:0] nf_r, nf_nxt;
  logic [hsd_pkg::SpW-1:0] sp_r, sp_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic last_r, last_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic leaf_r, leaf_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic pop_r, pop_nxt;
  logic [hsd_pkg::SlotW-1:0] slot_r, slot_nxt;
  logic root_leaf_r, root_leaf_nxt;
  logic [7:0] root_sym_r, root_sym_nxt;
  logic [NW-1:0] rl_r, rl_nxt, rr_r, rr_nxt;
  logic at_root_r, at_root_nxt;
  logic [NW-1:0] cl_r, cl_nxt, cr_r, cr_nxt;
  logic [NW-1:0] nx_r, nx_nxt;
  logic pv_r, pv_nxt;
  logic [7:0] psym_r, psym_nxt;
  logic ov_r, ov_nxt, orl_r, orl_nxt, ofd_r, ofd_nxt;
  logic [7:0] osym_r, osym_nxt;

  logic [NW-1:0] nt_raddr;
  logic ls_we, lc_we, rc_we;
  logic [NW-1:0] ls_waddr, lc_waddr, rc_waddr;
  logic [hsd_pkg::LsW-1:0] ls_wdata, ls_rdata;
  logic [NW-1:0] lc_wdata, lc_rdata, rc_wdata, rc_rdata;
  logic st_we;
  logic [hsd_pkg::StkAW-1:0] st_waddr, st_raddr;
  logic [hsd_pkg::SlotW-1:0] st_wdata, st_rdata;

  logic cur_bit, hit, full_tbl, complete, esc_start, take, tb_leaf, push_ok;
  logic [NW-1:0] nx, n_idx, par_idx;
  logic [7:0] hit_sym;
  logic [3:0] nbits;
  logic [12:0] tleft_or;

  hsd_ram #(.Width(hsd_pkg::LsW), .Depth(hsd_pkg::MaxNodes)) u_ls (
    .clk, .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(nt_raddr), .rdata(ls_rdata));
  hsd_ram #(.Width(NW), .Depth(hsd_pkg::MaxNodes)) u_lc (
    .clk, .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
    .raddr(nt_raddr), .rdata(lc_rdata));
  hsd_ram #(.Width(NW), .Depth(hsd_pkg::MaxNodes)) u_rc (
    .clk, .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .raddr(nt_raddr), .rdata(rc_rdata));
  hsd_ram #(.Width(hsd_pkg::SlotW), .Depth(hsd_pkg::StackDepth)) u_st (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));

  assign cur_bit = byte_r[3'd7 - bit_r];
  assign nx = at_root_r ? (cur_bit ? rr_r : rl_r) : (cur_bit ? cr_r : cl_r);
  assign hit = root_leaf_r || ls_rdata[8];
  assign hit_sym = root_leaf_r ? root_sym_r : ls_rdata[7:0];
  assign nbits = last_r ? (4'd8 - {1'b0, trash_r}) : 4'd8;
  assign full_tbl = nf_r >= hsd_pkg::NfW'(hsd_pkg::MaxNodes);
  assign complete = (nf_r != '0) && (sp_r == '0);
  assign esc_start = !esc_r && (byte_r == hsd_pkg::EscByte);
  assign take = !esc_start && !complete && !full_tbl;
  assign tb_leaf = esc_r || (byte_r != hsd_pkg::NodeByte);
  assign push_ok = !leaf_r &&
                   ((sp_r + hsd_pkg::SpW'(2)) <= hsd_pkg::SpW'(hsd_pkg::StackDepth));
  assign n_idx = nf_r[NW-1:0];
  assign par_idx = slot_r[hsd_pkg::SlotW-1:1];
  assign tleft_or = tleft_r | {5'd0, byte_r};

  always_comb begin
    phase_nxt = phase_r; trash_nxt = trash_r; tleft_nxt = tleft_r;
    esc_nxt = esc_r; nf_nxt = nf_r; sp_nxt = sp_r;
    byte_nxt = byte_r; last_nxt = last_r; bit_nxt = bit_r;
    leaf_nxt = leaf_r; n_nxt = n_r; pop_nxt = pop_r; slot_nxt = slot_r;
    root_leaf_nxt = root_leaf_r; root_sym_nxt = root_sym_r;
    rl_nxt = rl_r; rr_nxt = rr_r; at_root_nxt = at_root_r;
    cl_nxt = cl_r; cr_nxt = cr_r; nx_nxt = nx_r;
    pv_nxt = pv_r; psym_nxt = psym_r;
    ov_nxt = ov_r; orl_nxt = orl_r; ofd_nxt = ofd_r; osym_nxt = osym_r;
    nt_raddr = nx_r;
    ls_we = 1'b0; ls_waddr = n_idx; ls_wdata = {tb_leaf, byte_r};
    lc_we = 1'b0; lc_waddr = n_idx; lc_wdata = '0;
    rc_we = 1'b0; rc_waddr = n_idx; rc_wdata = '0;
    st_we = 1'b0; st_waddr = sp_r[hsd_pkg::StkAW-1:0]; st_wdata = {n_r, 1'b1};
    st_raddr = hsd_pkg::StkAW'(sp_r - hsd_pkg::SpW'(1));
    if (out_ready) ov_nxt = 1'b0;
    if (cmd.load_byte) begin
      byte_nxt = in_byte; last_nxt = last_byte; bit_nxt = '0;
    end
    if (cmd.head) begin
      if (phase_r == hsd_pkg::PH_HEAD0) begin
        trash_nxt = byte_r[7:5];
        tleft_nxt = {byte_r[4:0], 8'h00};
        phase_nxt = hsd_pkg::PH_HEAD1;
      end else begin
        tleft_nxt = tleft_or;
        phase_nxt = (tleft_or == '0) ? hsd_pkg::PH_DATA : hsd_pkg::PH_TREE;
        esc_nxt = 1'b0;
      end
    end
    if (cmd.tree_node) begin
      if (esc_r) esc_nxt = 1'b0;
      else if (byte_r == hsd_pkg::EscByte) esc_nxt = 1'b1;
      tleft_nxt = tleft_r - 13'd1;
      if (take) begin
        ls_we = 1'b1; lc_we = 1'b1; rc_we = 1'b1;
        nf_nxt = nf_r + hsd_pkg::NfW'(1);
        n_nxt = n_idx; leaf_nxt = tb_leaf;
        pop_nxt = sp_r != '0; slot_nxt = st_rdata;
        if (sp_r != '0) sp_nxt = sp_r - hsd_pkg::SpW'(1);
        if (n_idx == '0) begin
          root_leaf_nxt = tb_leaf; root_sym_nxt = byte_r;
          rl_nxt = '0; rr_nxt = '0;
        end
      end
      if (tleft_r == 13'd1) begin
        phase_nxt = hsd_pkg::PH_DATA; esc_nxt = 1'b0;
      end
    end
    if (cmd.tree_link) begin
      if (pop_r) begin
        if (slot_r[0]) begin
          rc_we = 1'b1; rc_waddr = par_idx; rc_wdata = n_r;
          if (par_idx == '0) rr_nxt = n_r;
        end else begin
          lc_we = 1'b1; lc_waddr = par_idx; lc_wdata = n_r;
          if (par_idx == '0) rl_nxt = n_r;
        end
      end
      if (push_ok) begin
        st_we = 1'b1; st_waddr = sp_r[hsd_pkg::StkAW-1:0]; st_wdata = {n_r, 1'b1};
      end
    end
    if (cmd.tree_push && push_ok) begin
      st_we = 1'b1;
      st_waddr = sp_r[hsd_pkg::StkAW-1:0] + hsd_pkg::StkAW'(1);
      st_wdata = {n_r, 1'b0};
      sp_nxt = sp_r + hsd_pkg::SpW'(2);
    end
    if (cmd.walk_read) begin
      nt_raddr = nx; nx_nxt = nx;
    end
    if (cmd.walk_eval) begin
      bit_nxt = bit_r + 3'd1;
      if (hit) begin
        if (pv_r) begin
          ov_nxt = 1'b1; osym_nxt = psym_r; orl_nxt = 1'b0; ofd_nxt = 1'b0;
        end
        pv_nxt = 1'b1; psym_nxt = hit_sym; at_root_nxt = 1'b1;
      end else begin
        at_root_nxt = 1'b0; cl_nxt = lc_rdata; cr_nxt = rc_rdata;
      end
    end
    if (cmd.data_end && pv_r) begin
      ov_nxt = 1'b1; osym_nxt = psym_r; orl_nxt = 1'b1; ofd_nxt = last_r;
      pv_nxt = 1'b0;
    end
    if (cmd.file_clear) begin
      phase_nxt = hsd_pkg::PH_HEAD0; trash_nxt = '0; tleft_nxt = '0;
      esc_nxt = 1'b0; nf_nxt = '0; sp_nxt = '0; at_root_nxt = 1'b1;
      root_leaf_nxt = 1'b0; pv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hsd_pkg::PH_HEAD0; trash_r <= '0; tleft_r <= '0; esc_r <= 1'b0;
      nf_r <= '0; sp_r <= '0; byte_r <= '0; last_r <= 1'b0; bit_r <= '0;
      leaf_r <= 1'b0; n_r <= '0; pop_r <= 1'b0; slot_r <= '0;
      root_leaf_r <= 1'b0; root_sym_r <= '0; rl_r <= '0; rr_r <= '0;
      at_root_r <= 1'b1; cl_r <= '0; cr_r <= '0; nx_r <= '0;
      pv_r <= 1'b0; psym_r <= '0;
      ov_r <= 1'b0; orl_r <= 1'b0; ofd_r <= 1'b0; osym_r <= '0;
    end else begin
      phase_r <= phase_nxt; trash_r <= trash_nxt; tleft_r <= tleft_nxt; esc_r <= esc_nxt;
      nf_r <= nf_nxt; sp_r <= sp_nxt; byte_r <= byte_nxt; last_r <= last_nxt;
      bit_r <= bit_nxt; leaf_r <= leaf_nxt; n_r <= n_nxt; pop_r <= pop_nxt;
      slot_r <= slot_nxt; root_leaf_r <= root_leaf_nxt; root_sym_r <= root_sym_nxt;
      rl_r <= rl_nxt; rr_r <= rr_nxt; at_root_r <= at_root_nxt;
      cl_r <= cl_nxt; cr_r <= cr_nxt; nx_r <= nx_nxt;
      pv_r <= pv_nxt; psym_r <= psym_nxt;
      ov_r <= ov_nxt; orl_r <= orl_nxt; ofd_r <= ofd_nxt; osym_r <= osym_nxt;
    end
  end

  assign sts.phase = phase_r;
  assign sts.last = last_r;
  assign sts.take = take;
  assign sts.have_nodes = nf_r != '0;
  assign sts.hit = hit;
  assign sts.pend_v = pv_r;
  assign sts.bits_last = ({1'b0, bit_r} + 4'd1) == nbits;
  assign sts.out_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_symbol = osym_r;
  assign out_run_last = orl_r;
  assign out_file_done = ofd_r;
endmodule

// ===== hw/rtl/hsd_ctrl.sv =====
// Controller state machine for the Huffman stream decoder.
// Depends on hsd_pkg and the assertion macro header.
`include "huffman_stream_decoder_assert.svh"
module hsd_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  hsd_pkg::sts_t sts,
  output hsd_pkg::cmd_t cmd
);
  hsd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      hsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          if (sts.phase inside {hsd_pkg::PH_HEAD0, hsd_pkg::PH_HEAD1}) begin
            state_nxt = hsd_pkg::ST_HEAD;
          end else if (sts.phase == hsd_pkg::PH_TREE) begin
            state_nxt = hsd_pkg::ST_TREE_NODE;
          end else begin
            state_nxt = hsd_pkg::ST_DATA_RD;
          end
        end
      end
      hsd_pkg::ST_HEAD: begin
        cmd.head = 1'b1;
        cmd.file_clear = sts.last;
        state_nxt = hsd_pkg::ST_IDLE;
      end
      hsd_pkg::ST_TREE_NODE: begin
        cmd.tree_node = 1'b1;
        if (sts.take) begin
          state_nxt = hsd_pkg::ST_TREE_LINK;
        end else begin
          cmd.file_clear = sts.last;
          state_nxt = hsd_pkg::ST_IDLE;
        end
      end
      hsd_pkg::ST_TREE_LINK: begin
        cmd.tree_link = 1'b1;
        state_nxt = hsd_pkg::ST_TREE_PUSH;
      end
      hsd_pkg::ST_TREE_PUSH: begin
        cmd.tree_push = 1'b1;
        cmd.file_clear = sts.last;
        state_nxt = hsd_pkg::ST_IDLE;
      end
      hsd_pkg::ST_DATA_RD: begin
        if (!sts.have_nodes) begin
          state_nxt = hsd_pkg::ST_DATA_END;
        end else begin
          cmd.walk_read = 1'b1;
          state_nxt = hsd_pkg::ST_DATA_EV;
        end
      end
      hsd_pkg::ST_DATA_EV: begin
        if (!(sts.hit && sts.pend_v && !sts.out_free)) begin
          cmd.walk_eval = 1'b1;
          state_nxt = sts.bits_last ? hsd_pkg::ST_DATA_END : hsd_pkg::ST_DATA_RD;
        end
      end
      hsd_pkg::ST_DATA_END: begin
        if (!(sts.pend_v && !sts.out_free)) begin
          cmd.data_end = 1'b1;
          cmd.file_clear = sts.last;
          state_nxt = hsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hsd_pkg::ST_IDLE;
    endcase
  end

  `HSD_ASSERT_IMPL(a_ready_idle, in_ready, state_r == hsd_pkg::ST_IDLE)
  `HSD_ASSERT_NEXT(a_load_leaves, cmd.load_byte, state_r != hsd_pkg::ST_IDLE)
  `HSD_ASSERT_IMPL(a_eval_free, cmd.walk_eval && sts.hit && sts.pend_v, sts.out_free)
endmodule

// ===== hw/rtl/huffman_stream_decoder.sv =====
// Top level of the Huffman stream decoder: controller, datapath, channels.
// Depends on hsd_pkg, hsd_if, hsd_ctrl, hsd_datapath, assertion header.
// One compressed byte per input transaction, one byte at a time. A header
// byte passes the head state; a tree byte passes the node state alone when
// it makes no node (escape mark, surplus byte, full table) and the node,
// link and push states when it does. A data byte takes a node table read
// and an evaluation per valid data bit, then an end step (only the end step
// with an empty tree); each decoded symbol is held back so that the data
// byte's last one can be marked; the walk stalls while it awaits the output.
`include "huffman_stream_decoder_assert.svh"
module huffman_stream_decoder (
  input logic clk,
  input logic rst_n,
  hsd_in_if.sink in_ch,
  hsd_out_if.source out_ch
);
  hsd_pkg::cmd_t cmd;
  hsd_pkg::sts_t sts;

  hsd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts, .cmd);

  hsd_datapath u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_ch.in_byte), .last_byte(in_ch.last_byte),
    .out_ready(out_ch.ready),
    .sts, .out_valid(out_ch.valid), .out_symbol(out_ch.symbol),
    .out_run_last(out_ch.run_last), .out_file_done(out_ch.file_done));

  `HSD_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  `HSD_ASSERT_NEXT(a_out_stable, out_ch.valid && !out_ch.ready, $stable(out_ch.symbol))
  `HSD_ASSERT_IMPL(a_no_take_busy, in_ch.ready, !cmd.walk_eval)
endmodule

// ===== tb/tb_top.sv =====
// Testbench for huffman_stream_decoder: compressed files go in byte by byte,
// decoded symbols are checked against an in-bench predictor of the decoder.
// Depends on hsd_pkg, hsd_if and the decoder RTL.
module tb_top;
  typedef struct {
    logic [7:0] symbol;
    logic run_last;
    logic file_done;
  } sym_exp_t;

  logic clk;
  logic rst_n;
  int unsigned fail_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  hsd_in_if in_ch (.clk(clk));
  hsd_out_if out_ch (.clk(clk));

  huffman_stream_decoder i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor state
  logic        nt_leaf [hsd_pkg::MaxNodes];
  logic [7:0]  nt_sym [hsd_pkg::MaxNodes];
  int unsigned nt_left [hsd_pkg::MaxNodes];
  int unsigned nt_right [hsd_pkg::MaxNodes];
  int unsigned bstack [hsd_pkg::StackDepth];
  hsd_pkg::phase_t p_phase;
  int unsigned p_trash;
  int unsigned p_left_cnt;
  bit          p_esc;
  int unsigned p_nfree;
  int unsigned p_sp;
  int unsigned p_walk;
  sym_exp_t    sym_q[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_file();
    p_phase = hsd_pkg::PH_HEAD0;
    p_trash = 0;
    p_left_cnt = 0;
    p_esc = 1'b0;
    p_nfree = 0;
    p_sp = 0;
    p_walk = 0;
  endfunction

  function automatic void build_node(logic [7:0] b);
    bit leaf;
    int unsigned n;
    int unsigned slot;
    if (p_esc) begin
      p_esc = 1'b0;
      leaf = 1'b1;
    end else if (b == hsd_pkg::EscByte) begin
      p_esc = 1'b1;
      return;
    end else begin
      leaf = (b != hsd_pkg::NodeByte);
    end
    if (p_nfree != 0 && p_sp == 0) return;
    if (p_nfree >= hsd_pkg::MaxNodes) return;
    n = p_nfree;
    p_nfree = n + 1;
    if (p_sp > 0 && p_sp <= hsd_pkg::StackDepth) begin
      p_sp = p_sp - 1;
      slot = bstack[p_sp];
      if ((slot >> 1) < hsd_pkg::MaxNodes) begin
        if (slot & 1) nt_right[slot >> 1] = n;
        else nt_left[slot >> 1] = n;
      end
    end
    nt_leaf[n] = leaf;
    nt_sym[n] = b;
    nt_left[n] = 0;
    nt_right[n] = 0;
    if (!leaf && p_sp + 2 <= hsd_pkg::StackDepth) begin
      bstack[p_sp] = (n << 1) | 1;
      bstack[p_sp + 1] = n << 1;
      p_sp = p_sp + 2;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    int unsigned nbits;
    int unsigned nx;
    int unsigned first;
    sym_exp_t e;
    first = sym_q.size();
    case (p_phase)
      hsd_pkg::PH_HEAD0: begin
        p_trash = b[7:5];
        p_left_cnt = {b[4:0], 8'h00};
        p_phase = hsd_pkg::PH_HEAD1;
      end
      hsd_pkg::PH_HEAD1: begin
        p_left_cnt = (p_left_cnt | b) & 16'h1FFF;
        p_phase = (p_left_cnt == 0) ? hsd_pkg::PH_DATA : hsd_pkg::PH_TREE;
        p_esc = 1'b0;
      end
      hsd_pkg::PH_TREE: begin
        build_node(b);
        p_left_cnt = p_left_cnt - 1;
        if (p_left_cnt == 0) begin
          p_phase = hsd_pkg::PH_DATA;
          p_esc = 1'b0;
        end
      end
      default: begin
        nbits = last ? 8 - p_trash : 8;
        if (p_nfree != 0) begin
          for (int i = 0; i < nbits; i++) begin
            e.run_last = 1'b0;
            e.file_done = 1'b0;
            if (nt_leaf[0]) begin
              e.symbol = nt_sym[0];
              sym_q.push_back(e);
            end else begin
              nx = b[7 - i] ? nt_right[p_walk] : nt_left[p_walk];
              if (nx >= hsd_pkg::MaxNodes) nx = 0;
              if (nt_leaf[nx]) begin
                e.symbol = nt_sym[nx];
                sym_q.push_back(e);
                p_walk = 0;
              end else begin
                p_walk = nx;
              end
            end
          end
          if (sym_q.size() > first) begin
            sym_q[$].run_last = 1'b1;
            sym_q[$].file_done = last;
          end
        end
      end
    endcase
    if (last) clear_file();
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, last);
  endtask

  task automatic send_file(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sym_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // header + tree + data; tree of four leaves: * * a b * c \*
  function automatic void make_file(ref logic [7:0] f[$], input int unsigned trash,
                                    input logic [7:0] tree[$], input int unsigned ndata);
    f = {};
    f.push_back({trash[2:0], 5'(tree.size() >> 8)});
    f.push_back(8'(tree.size()));
    foreach (tree[i]) f.push_back(tree[i]);
    repeat (ndata) f.push_back(8'($urandom));
  endfunction

  function automatic void rand_tree(ref logic [7:0] t[$], input int unsigned leaves);
    int unsigned open;
    logic [7:0] s;
    t = {};
    open = 1;
    while (open > 0) begin
      if (leaves > 1 && $urandom_range(1)) begin
        t.push_back(hsd_pkg::NodeByte);
        open++;
        leaves--;
      end else begin
        s = 8'($urandom);
        if (s == hsd_pkg::EscByte || s == hsd_pkg::NodeByte || $urandom_range(5) == 0)
          t.push_back(hsd_pkg::EscByte);
        t.push_back(s);
        open--;
      end
    end
  endfunction

  task automatic test_directed();
    logic [7:0] f[$];
    logic [7:0] t[$];
    t = '{hsd_pkg::NodeByte, hsd_pkg::NodeByte, 8'h61, 8'h62, hsd_pkg::NodeByte, 8'h63,
          hsd_pkg::EscByte, hsd_pkg::NodeByte};
    make_file(f, 7, t, 3);
    f[$] = 8'hFF;
    send_file(f);
    make_file(f, 0, t, 2);
    f[f.size() - 2] = 8'h00;
    send_file(f);
    // one-leaf tree, three trash bits in the last data byte
    t = '{8'hFF};
    make_file(f, 3, t, 2);
    send_file(f);
    // zero tree count
    send_file('{8'h00, 8'h00, 8'hA5});
    // complete tree with a surplus escape byte at its end
    t = '{hsd_pkg::NodeByte, hsd_pkg::NodeByte, 8'h41, 8'h42, 8'h43, hsd_pkg::EscByte};
    make_file(f, 1, t, 2);
    f[$ - 1] = 8'h5A;
    send_file(f);
    // early end in header and in tree, then a tree with unfilled children
    send_byte(8'h00, 1'b1);
    send_file('{8'h00, 8'h05, hsd_pkg::NodeByte});
    t = '{hsd_pkg::NodeByte};
    make_file(f, 0, t, 1);
    send_file(f);
  endtask

  task automatic test_random(int unsigned n_items);
    logic [7:0] f[$];
    logic [7:0] t[$];
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        f = {};
        repeat ($urandom_range(1, 5)) f.push_back(8'($urandom));
      end else begin
        rand_tree(t, $urandom_range(1, 9));
        make_file(f, $urandom_range(7), t, $urandom_range(1, 6));
      end
      send_file(f);
      sent += f.size();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sym_q.size() == 0) begin
        $display("%0t: unexpected symbol %h", $time, out_ch.symbol);
        fail_cnt++;
      end else begin
        if (out_ch.symbol !== sym_q[0].symbol || out_ch.run_last !== sym_q[0].run_last ||
            out_ch.file_done !== sym_q[0].file_done) begin
          $display("%0t: expected sym %h last %b done %b, actual sym %h last %b done %b",
                   $time, sym_q[0].symbol, sym_q[0].run_last, sym_q[0].file_done,
                   out_ch.symbol, out_ch.run_last, out_ch.file_done);
          fail_cnt++;
        end
        void'(sym_q.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    fail_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    clear_file();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(12);
    src_idle_pct = 57;
    test_random(12);
    wait_drained();
    src_idle_pct = 0;
    snk_stall_pct = 57;
    test_random(12);
    src_idle_pct = 25;
    snk_stall_pct = 25;
    test_random(12);
    wait_drained();
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== huffman_stream_decoder.f =====
+incdir+hw/rtl
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_if.sv
hw/rtl/hsd_ram.sv
hw/rtl/hsd_datapath.sv
hw/rtl/hsd_ctrl.sv
hw/rtl/huffman_stream_decoder.sv
tb/tb_top.sv
